### sv/nelr_pkg.sv
// Shared constants and controller/datapath interface types for the note event loop recorder.
package nelr_pkg;

   localparam logic [7:0]  KIND_PRESS     = 8'h50;
   localparam logic [7:0]  KIND_RELEASE   = 8'h52;
   localparam logic [15:0] MAX_TIME_RESET = 16'd1667;
   localparam logic [15:0] REL_STAMP_GAP  = 16'd5;
   localparam int          RESULT_CAP     = 52;

   localparam logic CSR_MAX_TIME = 1'b0;
   localparam logic CSR_ROUTE    = 1'b1;

   typedef struct packed {
      logic load;
      logic decide_rec;
      logic decide_play;
      logic limit;
      logic record;
      logic li_clr;
      logic li_inc;
      logic lt_zero;
      logic lt_sel;
      logic lt_inc;
      logic h_sel;
      logic hrd;
      logic cnt_clr;
      logic emit_rel;
      logic sr_app;
      logic non_ins;
      logic nof_dec;
      logic sh_wr;
      logic erd;
      logic pl_hit;
      logic tick_inc;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic rec_stop;
      logic rec_start;
      logic play_stop;
      logic over;
      logic rec_on;
      logic play_on;
      logic tick_zero;
      logic rec_new;
      logic kind_p;
      logic kind_r;
      logic li_lt_cnt;
      logic h_match;
      logic lt_last;
      logic lt_play_last;
      logic pl_active;
      logic pl_hit;
      logic ev_p;
      logic ev_r;
      logic skip;
   } status_type;

endpackage

### sv/nelr_ctrl.sv
// Sequencer that walks one tick through its decision, release, record and playback steps.
module nelr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  nelr_pkg::status_type sts,
   output nelr_pkg::cmd_type    cmd
);
   import nelr_pkg::*;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_DECIDE  = 5'd1;
   localparam logic [4:0] S_PLAYDEC = 5'd2;
   localparam logic [4:0] S_LIMIT   = 5'd3;
   localparam logic [4:0] S_REC     = 5'd4;
   localparam logic [4:0] S_SR_A    = 5'd5;
   localparam logic [4:0] S_SR_D    = 5'd6;
   localparam logic [4:0] S_REL_A   = 5'd7;
   localparam logic [4:0] S_REL_D   = 5'd8;
   localparam logic [4:0] S_NON_A   = 5'd9;
   localparam logic [4:0] S_NON_D   = 5'd10;
   localparam logic [4:0] S_NOF_A   = 5'd11;
   localparam logic [4:0] S_NOF_D   = 5'd12;
   localparam logic [4:0] S_SH_A    = 5'd13;
   localparam logic [4:0] S_SH_D    = 5'd14;
   localparam logic [4:0] S_PLAY_S  = 5'd15;
   localparam logic [4:0] S_PLAY_A  = 5'd16;
   localparam logic [4:0] S_PLAY_D  = 5'd17;
   localparam logic [4:0] S_PLAY_N  = 5'd18;
   localparam logic [4:0] S_TICK    = 5'd19;
   localparam logic [4:0] S_FLUSH   = 5'd20;

   localparam logic [1:0] RET_PLAYDEC = 2'd0;
   localparam logic [1:0] RET_LIMIT   = 2'd1;
   localparam logic [1:0] RET_RECORD  = 2'd2;

   logic [4:0] state_ff, state_in;
   logic [1:0] ret_ff, ret_in;
   logic       all_ff, all_in;
   logic       nret_ff, nret_in;
   logic [4:0] rel_ret;
   logic [4:0] note_ret;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      unique case (ret_ff)
         RET_PLAYDEC: rel_ret = S_PLAYDEC;
         RET_LIMIT:   rel_ret = S_LIMIT;
         default:     rel_ret = S_REC;
      endcase
      note_ret = nret_ff ? S_PLAY_N : S_PLAY_S;
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ret_in   = ret_ff;
      all_in   = all_ff;
      nret_in  = nret_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide_rec = 1'b1;
            cmd.li_clr     = 1'b1;
            ret_in         = RET_PLAYDEC;
            all_in         = 1'b0;
            if (sts.rec_stop) begin
               cmd.lt_sel = 1'b1;
               state_in   = S_SR_A;
            end else if (sts.rec_start) begin
               cmd.lt_zero = 1'b1;
               all_in      = 1'b1;
               state_in    = S_REL_A;
            end else begin
               state_in = S_PLAYDEC;
            end
         end
         S_PLAYDEC: begin
            cmd.decide_play = 1'b1;
            cmd.li_clr      = 1'b1;
            cmd.lt_sel      = 1'b1;
            ret_in          = RET_LIMIT;
            all_in          = 1'b0;
            state_in        = sts.play_stop ? S_REL_A : S_LIMIT;
         end
         S_LIMIT: begin
            cmd.limit  = 1'b1;
            cmd.li_clr = 1'b1;
            cmd.lt_sel = 1'b1;
            ret_in     = RET_RECORD;
            all_in     = 1'b0;
            if (sts.over) begin
               state_in = sts.rec_on ? S_SR_A : S_REL_A;
            end else begin
               state_in = S_REC;
            end
         end
         S_SR_A: begin
            if (sts.li_lt_cnt) begin
               cmd.hrd  = 1'b1;
               state_in = S_SR_D;
            end else begin
               cmd.li_clr = 1'b1;
               state_in   = S_REL_A;
            end
         end
         S_SR_D: begin
            cmd.sr_app = 1'b1;
            cmd.li_inc = 1'b1;
            state_in   = S_SR_A;
         end
         S_REL_A: begin
            if (sts.li_lt_cnt) begin
               cmd.hrd  = 1'b1;
               state_in = S_REL_D;
            end else begin
               cmd.cnt_clr = 1'b1;
               cmd.li_clr  = 1'b1;
               if (all_ff && !sts.lt_last) begin
                  cmd.lt_inc = 1'b1;
               end else begin
                  state_in = rel_ret;
               end
            end
         end
         S_REL_D: begin
            cmd.emit_rel = 1'b1;
            cmd.li_inc   = 1'b1;
            state_in     = S_REL_A;
         end
         S_REC: begin
            cmd.record = 1'b1;
            cmd.li_clr = 1'b1;
            nret_in    = 1'b0;
            if (sts.rec_on && !sts.tick_zero && sts.rec_new && sts.kind_p) begin
               state_in = S_NON_A;
            end else if (sts.rec_on && !sts.tick_zero && sts.rec_new && sts.kind_r) begin
               state_in = S_NOF_A;
            end else begin
               state_in = S_PLAY_S;
            end
         end
         S_NON_A: begin
            cmd.h_sel = 1'b1;
            if (sts.li_lt_cnt) begin
               cmd.hrd  = 1'b1;
               state_in = S_NON_D;
            end else begin
               cmd.non_ins = 1'b1;
               state_in    = note_ret;
            end
         end
         S_NON_D: begin
            cmd.h_sel = 1'b1;
            if (sts.h_match) begin
               state_in = note_ret;
            end else begin
               cmd.li_inc = 1'b1;
               state_in   = S_NON_A;
            end
         end
         S_NOF_A: begin
            cmd.h_sel = 1'b1;
            if (sts.li_lt_cnt) begin
               cmd.hrd  = 1'b1;
               state_in = S_NOF_D;
            end else begin
               state_in = note_ret;
            end
         end
         S_NOF_D: begin
            cmd.h_sel  = 1'b1;
            cmd.li_inc = 1'b1;
            state_in   = sts.h_match ? S_SH_A : S_NOF_A;
         end
         S_SH_A: begin
            cmd.h_sel = 1'b1;
            if (sts.li_lt_cnt) begin
               cmd.hrd  = 1'b1;
               state_in = S_SH_D;
            end else begin
               cmd.nof_dec = 1'b1;
               state_in    = note_ret;
            end
         end
         S_SH_D: begin
            cmd.h_sel  = 1'b1;
            cmd.sh_wr  = 1'b1;
            cmd.li_inc = 1'b1;
            state_in   = S_SH_A;
         end
         S_PLAY_S: begin
            cmd.lt_zero = 1'b1;
            if (sts.skip) begin
               state_in = S_FLUSH;
            end else if (!sts.play_on) begin
               state_in = S_TICK;
            end else begin
               state_in = S_PLAY_A;
            end
         end
         S_PLAY_A: begin
            if (sts.pl_active) begin
               cmd.erd  = 1'b1;
               state_in = S_PLAY_D;
            end else begin
               state_in = S_PLAY_N;
            end
         end
         S_PLAY_D: begin
            nret_in = 1'b1;
            if (sts.pl_hit) begin
               cmd.pl_hit = 1'b1;
               cmd.li_clr = 1'b1;
               if (sts.ev_p) begin
                  state_in = S_NON_A;
               end else if (sts.ev_r) begin
                  state_in = S_NOF_A;
               end else begin
                  state_in = S_PLAY_N;
               end
            end else begin
               state_in = S_PLAY_N;
            end
         end
         S_PLAY_N: begin
            if (sts.lt_play_last) begin
               state_in = S_TICK;
            end else begin
               cmd.lt_inc = 1'b1;
               state_in   = S_PLAY_A;
            end
         end
         S_TICK: begin
            cmd.tick_inc = 1'b1;
            state_in     = S_FLUSH;
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= RET_PLAYDEC;
         all_ff   <= 1'b0;
         nret_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         all_ff   <= all_in;
         nret_ff  <= nret_in;
      end
   end

   a_start_goes_decide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start) |=> state_ff == S_DECIDE)
      else $error("accepted item did not enter decision step");
   a_flush_ends_tick: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLUSH |=> state_ff == S_IDLE)
      else $error("flush did not return to idle");
   a_rel_data_after_addr: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REL_D |-> $past(state_ff) == S_REL_A)
      else $error("release data step without read");

endmodule

### sv/nelr_datapath.sv
// Track stores, held-note lists, tick counter and result registers of the loop recorder.
module nelr_datapath #(
   parameter int TRACKS           = 4,
   parameter int EVENTS_PER_TRACK = 128,
   parameter int HELD_PER_TRACK   = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  nelr_pkg::cmd_type    cmd,
   output nelr_pkg::status_type sts,
   input  logic                 rec_request,
   input  logic                 play_request,
   input  logic [1:0]           track_select,
   input  logic [3:0]           track_enable,
   input  logic [7:0]           msg_kind,
   input  logic [7:0]           msg_octave,
   input  logic [7:0]           msg_key,
   input  logic [7:0]           msg_volume,
   input  logic [15:0]          msg_index,
   input  logic [15:0]          msg_extra,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [15:0]          csr_write_data,
   output logic                 rsp_valid,
   output logic                 rsp_event_valid,
   output logic [7:0]           rsp_ev_kind,
   output logic [7:0]           rsp_ev_octave,
   output logic [7:0]           rsp_ev_key,
   output logic [7:0]           rsp_ev_volume,
   output logic [15:0]          rsp_ev_index,
   output logic [15:0]          rsp_ev_extra,
   output logic                 rsp_destination,
   output logic                 rsp_recording_auto_stopped,
   output logic                 rsp_last
);
   import nelr_pkg::*;

   localparam int TW  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
   localparam int LW  = $clog2(EVENTS_PER_TRACK + 1);
   localparam int PW  = $clog2(EVENTS_PER_TRACK);
   localparam int EAW = $clog2(TRACKS * EVENTS_PER_TRACK);
   localparam int CW  = $clog2(HELD_PER_TRACK + 1);
   localparam int HAW = $clog2(TRACKS * HELD_PER_TRACK);
   localparam int PT  = (TRACKS < 4) ? TRACKS : 4;
   localparam int NW  = $clog2(RESULT_CAP + 1);

   logic [63:0] evmem [TRACKS*EVENTS_PER_TRACK];
   logic [15:0] hmem  [TRACKS*HELD_PER_TRACK];

   logic [LW-1:0] len_ff [TRACKS];
   logic [PW-1:0] ptr_ff [TRACKS];
   logic [CW-1:0] cnt_ff [TRACKS];

   logic          rr_ff, pr_ff;
   logic [TW-1:0] sel_ff;
   logic [3:0]    en_ff;
   logic [7:0]    kind_ff, oct_ff, key_ff, vol_ff;
   logic [15:0]   midx_ff, extra_ff;

   logic [15:0]   tick_ff, maxt_ff, base_ff, note_ff, hrd_ff;
   logic          rec_ff, play_ff, route_ff, auto_ff, skip_ff;
   logic [23:0]   prev_ff;
   logic [CW-1:0] li_ff;
   logic [TW-1:0] lt_ff;
   logic [NW-1:0] nout_ff;
   logic [63:0]   pend_ff, erd_ff;

   logic          rsp_valid_ff, rsp_event_valid_ff, rsp_last_ff;
   logic          rsp_dest_ff, rsp_auto_ff;
   logic [63:0]   rsp_data_ff;

   logic [3:0]     sel_mod;
   logic [23:0]    cur;
   logic [TW-1:0]  htrk;
   logic [CW-1:0]  hcnt;
   logic [HAW-1:0] haddr_rd, haddr_wr;
   logic           hwr_en;
   logic [15:0]    hwr_data;
   logic [LW-1:0]  plen;
   logic [PW-1:0]  p_eff, p_next;
   logic [EAW-1:0] eaddr_rd, eaddr_wr;
   logic [7:0]     en8;
   logic           rec_new;
   logic           app_en;
   logic [63:0]    app_data;
   logic [15:0]    sr_stamp;
   logic           emit_en;
   logic [63:0]    emit_data;

   always_comb begin
      sel_mod = {2'b00, track_select};
      for (int k = 0; k < 3; k++) begin
         if (sel_mod >= 4'(TRACKS)) sel_mod = sel_mod - 4'(TRACKS);
      end
   end

   assign cur      = {kind_ff, oct_ff, key_ff};
   assign rec_new  = (midx_ff == 16'd0) && (cur != prev_ff);
   assign htrk     = cmd.h_sel ? sel_ff : lt_ff;
   assign hcnt     = cnt_ff[htrk];
   assign haddr_rd = HAW'(32'(htrk) * 32'(HELD_PER_TRACK) + 32'(li_ff));
   assign en8      = {4'b0000, en_ff};
   assign plen     = len_ff[lt_ff];
   assign p_eff    = (LW'(ptr_ff[lt_ff]) >= plen) ? '0 : ptr_ff[lt_ff];
   assign p_next   = (LW'(p_eff) + LW'(1) == plen) ? '0 : p_eff + PW'(1);
   assign eaddr_rd = EAW'(32'(lt_ff) * 32'(EVENTS_PER_TRACK) + 32'(p_eff));
   assign eaddr_wr = EAW'(32'(sel_ff) * 32'(EVENTS_PER_TRACK) + 32'(len_ff[sel_ff]));
   assign sr_stamp = base_ff - 16'(cnt_ff[lt_ff]) - REL_STAMP_GAP + 16'(li_ff);

   assign app_en   = cmd.sr_app ||
                     (cmd.record && rec_ff && (tick_ff != 16'd0) && rec_new);
   assign app_data = cmd.sr_app ?
                     {KIND_RELEASE, hrd_ff, 8'h00, sr_stamp, 16'h0000} :
                     {kind_ff, oct_ff, key_ff, vol_ff, tick_ff, extra_ff};

   assign emit_en   = cmd.emit_rel || cmd.pl_hit;
   assign emit_data = cmd.emit_rel ? {KIND_RELEASE, hrd_ff, 40'h0} : erd_ff;

   always_comb begin
      hwr_en   = 1'b0;
      haddr_wr = HAW'(32'(sel_ff) * 32'(HELD_PER_TRACK) + 32'(cnt_ff[sel_ff]));
      hwr_data = note_ff;
      if (cmd.non_ins && (cnt_ff[sel_ff] < CW'(HELD_PER_TRACK))) begin
         hwr_en = 1'b1;
      end else if (cmd.sh_wr) begin
         hwr_en   = 1'b1;
         haddr_wr = HAW'(32'(sel_ff) * 32'(HELD_PER_TRACK) + 32'(li_ff) - 32'd1);
         hwr_data = hrd_ff;
      end
   end

   always_comb begin
      sts              = '0;
      sts.rec_stop     = rec_ff && !rr_ff;
      sts.rec_start    = !rec_ff && rr_ff;
      sts.play_stop    = play_ff && !pr_ff;
      sts.over         = tick_ff > maxt_ff;
      sts.rec_on       = rec_ff;
      sts.play_on      = play_ff;
      sts.tick_zero    = (tick_ff == 16'd0);
      sts.rec_new      = rec_new;
      sts.kind_p       = (kind_ff == KIND_PRESS);
      sts.kind_r       = (kind_ff == KIND_RELEASE);
      sts.li_lt_cnt    = li_ff < hcnt;
      sts.h_match      = (hrd_ff == note_ff);
      sts.lt_last      = (lt_ff == TW'(TRACKS - 1));
      sts.lt_play_last = (lt_ff == TW'(PT - 1));
      sts.pl_active    = en8[lt_ff] && (plen != '0);
      sts.pl_hit       = (erd_ff[31:16] == tick_ff);
      sts.ev_p         = (erd_ff[63:56] == KIND_PRESS);
      sts.ev_r         = (erd_ff[63:56] == KIND_RELEASE);
      sts.skip         = skip_ff;
   end

   always_ff @(posedge clock) begin
      if (app_en && (len_ff[sel_ff] < LW'(EVENTS_PER_TRACK))) begin
         evmem[eaddr_wr] <= app_data;
      end
      if (cmd.erd) begin
         erd_ff <= evmem[eaddr_rd];
      end
   end

   always_ff @(posedge clock) begin
      if (hwr_en) begin
         hmem[haddr_wr] <= hwr_data;
      end
      if (cmd.hrd) begin
         hrd_ff <= hmem[haddr_rd];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rr_ff    <= rec_request;
         pr_ff    <= play_request;
         sel_ff   <= sel_mod[TW-1:0];
         en_ff    <= track_enable;
         kind_ff  <= msg_kind;
         oct_ff   <= msg_octave;
         key_ff   <= msg_key;
         vol_ff   <= msg_volume;
         midx_ff  <= msg_index;
         extra_ff <= msg_extra;
      end
      if (cmd.li_clr) begin
         li_ff <= '0;
      end else if (cmd.li_inc) begin
         li_ff <= li_ff + CW'(1);
      end
      if (cmd.lt_zero) begin
         lt_ff <= '0;
      end else if (cmd.lt_sel) begin
         lt_ff <= sel_ff;
      end else if (cmd.lt_inc) begin
         lt_ff <= lt_ff + TW'(1);
      end
      if (emit_en && (nout_ff < NW'(RESULT_CAP))) begin
         pend_ff <= emit_data;
      end
      if (cmd.pl_hit) begin
         note_ff <= erd_ff[55:40];
      end else if (cmd.record && rec_ff && (tick_ff != 16'd0) && rec_new) begin
         note_ff <= {oct_ff, key_ff};
      end
      if (cmd.decide_rec && rec_ff && !rr_ff) begin
         base_ff <= tick_ff;
      end else if (cmd.limit && (tick_ff > maxt_ff) && rec_ff) begin
         base_ff <= maxt_ff;
      end
      if (cmd.flush) begin
         rsp_data_ff <= (nout_ff != '0) ? pend_ff : 64'h0;
      end else if (emit_en && (nout_ff < NW'(RESULT_CAP))) begin
         rsp_data_ff <= pend_ff;
      end
      rsp_dest_ff <= route_ff;
      rsp_auto_ff <= auto_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < TRACKS; t++) begin
            len_ff[t] <= '0;
            ptr_ff[t] <= '0;
            cnt_ff[t] <= '0;
         end
         tick_ff            <= '0;
         rec_ff             <= 1'b0;
         play_ff            <= 1'b0;
         prev_ff            <= '0;
         maxt_ff            <= MAX_TIME_RESET;
         route_ff           <= 1'b0;
         auto_ff            <= 1'b0;
         skip_ff            <= 1'b0;
         nout_ff            <= '0;
         rsp_valid_ff       <= 1'b0;
         rsp_event_valid_ff <= 1'b0;
         rsp_last_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_MAX_TIME: maxt_ff  <= csr_write_data;
               CSR_ROUTE:    route_ff <= csr_write_data[0];
               default:      maxt_ff  <= maxt_ff;
            endcase
         end
         if (cmd.load) begin
            nout_ff <= '0;
            skip_ff <= 1'b0;
            auto_ff <= 1'b0;
         end
         if (cmd.decide_rec) begin
            auto_ff <= rr_ff && rec_ff && !(!play_ff && pr_ff) && (tick_ff > maxt_ff);
            if (rec_ff && !rr_ff) begin
               tick_ff <= '0;
               rec_ff  <= 1'b0;
            end else if (!rec_ff && rr_ff) begin
               rec_ff          <= 1'b1;
               tick_ff         <= '0;
               len_ff[sel_ff]  <= '0;
               ptr_ff[sel_ff]  <= '0;
            end
         end
         if (cmd.decide_play) begin
            if (play_ff && !pr_ff) begin
               play_ff <= 1'b0;
            end else if (!play_ff && pr_ff) begin
               play_ff <= 1'b1;
               tick_ff <= '0;
               for (int t = 0; t < TRACKS; t++) ptr_ff[t] <= '0;
            end
         end
         if (cmd.limit && (tick_ff > maxt_ff)) begin
            tick_ff <= '0;
            rec_ff  <= 1'b0;
            for (int t = 0; t < TRACKS; t++) ptr_ff[t] <= '0;
         end
         if (cmd.record && rec_ff) begin
            if (tick_ff == 16'd0) begin
               tick_ff <= 16'd1;
               prev_ff <= cur;
               skip_ff <= 1'b1;
            end else if (rec_new) begin
               prev_ff <= cur;
            end
         end
         if (app_en && (len_ff[sel_ff] < LW'(EVENTS_PER_TRACK))) begin
            len_ff[sel_ff] <= len_ff[sel_ff] + LW'(1);
         end
         if (cmd.cnt_clr) begin
            cnt_ff[lt_ff] <= '0;
         end else if (cmd.non_ins && (cnt_ff[sel_ff] < CW'(HELD_PER_TRACK))) begin
            cnt_ff[sel_ff] <= cnt_ff[sel_ff] + CW'(1);
         end else if (cmd.nof_dec) begin
            cnt_ff[sel_ff] <= cnt_ff[sel_ff] - CW'(1);
         end
         if (cmd.pl_hit) begin
            ptr_ff[lt_ff] <= p_next;
         end
         if (cmd.tick_inc && (rec_ff || play_ff)) begin
            tick_ff <= tick_ff + 16'd1;
         end
         if (emit_en && (nout_ff < NW'(RESULT_CAP))) begin
            nout_ff <= nout_ff + NW'(1);
            if (nout_ff != '0) begin
               rsp_valid_ff       <= 1'b1;
               rsp_event_valid_ff <= 1'b1;
               rsp_last_ff        <= 1'b0;
            end
         end
         if (cmd.flush) begin
            rsp_valid_ff       <= 1'b1;
            rsp_event_valid_ff <= (nout_ff != '0);
            rsp_last_ff        <= 1'b1;
         end
      end
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_event_valid            = rsp_event_valid_ff;
   assign rsp_ev_kind                = rsp_data_ff[63:56];
   assign rsp_ev_octave              = rsp_data_ff[55:48];
   assign rsp_ev_key                 = rsp_data_ff[47:40];
   assign rsp_ev_volume              = rsp_data_ff[39:32];
   assign rsp_ev_index               = rsp_data_ff[31:16];
   assign rsp_ev_extra               = rsp_data_ff[15:0];
   assign rsp_destination            = rsp_dest_ff;
   assign rsp_recording_auto_stopped = rsp_auto_ff;
   assign rsp_last                   = rsp_last_ff;

   a_flush_gives_last: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> rsp_valid_ff && rsp_last_ff)
      else $error("tick closed without final item");
   a_last_then_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |=> !rsp_valid_ff)
      else $error("item delivered after final item of tick");

endmodule

### sv/note_event_loop_recorder_unit.sv
// Top level of the four-track note event loop recorder.
// Each held note walked takes a read step and a data step on the held-note memory;
//   each enabled track checked in playback takes a read of the event memory read port.
// Throughput: one item at a time; start is taken again in the same cycle as the final item is shown.
// Results leave from registers one per cycle, marked by rsp_valid; the receiver cannot stall.
// Reset clears control, counters, lengths and pointers; stores hold junk until written.
module note_event_loop_recorder_unit #(
   parameter int TRACKS           = 4,
   parameter int EVENTS_PER_TRACK = 128,
   parameter int HELD_PER_TRACK   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_rec_request,
   input  logic        req_play_request,
   input  logic [1:0]  req_track_select,
   input  logic [3:0]  req_track_enable,
   input  logic [7:0]  req_msg_kind,
   input  logic [7:0]  req_msg_octave,
   input  logic [7:0]  req_msg_key,
   input  logic [7:0]  req_msg_volume,
   input  logic [15:0] req_msg_index,
   input  logic [15:0] req_msg_extra,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data,
   output logic        rsp_valid,
   output logic        rsp_event_valid,
   output logic [7:0]  rsp_ev_kind,
   output logic [7:0]  rsp_ev_octave,
   output logic [7:0]  rsp_ev_key,
   output logic [7:0]  rsp_ev_volume,
   output logic [15:0] rsp_ev_index,
   output logic [15:0] rsp_ev_extra,
   output logic        rsp_destination,
   output logic        rsp_recording_auto_stopped,
   output logic        rsp_last
);
   import nelr_pkg::*;

   cmd_type    cmd;
   status_type sts;

   nelr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   nelr_datapath #(
      .TRACKS           (TRACKS),
      .EVENTS_PER_TRACK (EVENTS_PER_TRACK),
      .HELD_PER_TRACK   (HELD_PER_TRACK)
   ) u_datapath (
      .clock                      (clock),
      .reset                      (reset),
      .cmd                        (cmd),
      .sts                        (sts),
      .rec_request                (req_rec_request),
      .play_request               (req_play_request),
      .track_select               (req_track_select),
      .track_enable               (req_track_enable),
      .msg_kind                   (req_msg_kind),
      .msg_octave                 (req_msg_octave),
      .msg_key                    (req_msg_key),
      .msg_volume                 (req_msg_volume),
      .msg_index                  (req_msg_index),
      .msg_extra                  (req_msg_extra),
      .csr_write_enable           (csr_write_enable),
      .csr_index                  (csr_index),
      .csr_write_data             (csr_write_data),
      .rsp_valid                  (rsp_valid),
      .rsp_event_valid            (rsp_event_valid),
      .rsp_ev_kind                (rsp_ev_kind),
      .rsp_ev_octave              (rsp_ev_octave),
      .rsp_ev_key                 (rsp_ev_key),
      .rsp_ev_volume              (rsp_ev_volume),
      .rsp_ev_index               (rsp_ev_index),
      .rsp_ev_extra               (rsp_ev_extra),
      .rsp_destination            (rsp_destination),
      .rsp_recording_auto_stopped (rsp_recording_auto_stopped),
      .rsp_last                   (rsp_last)
   );

endmodule
